@@ design/websocket_frame_unmasker_assert.svh @@
// assertion macros for the top module, which checks itself
`ifndef WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH

// same-cycle implication
`define WSU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wsu_pkg.sv @@
package wsu_pkg;

  localparam logic [7:0] OPC_TEXT = 8'h81;
  localparam logic [7:0] OPC_PING = 8'h89;
  localparam logic [7:0] OPC_PONG = 8'h8a;
  localparam logic [7:0] LEN_MASK = 8'h7f;
  localparam logic [7:0] LEN_EXT16 = 8'd126;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CLS_DISCARD = 2'd0,
    CLS_TEXT    = 2'd1,
    CLS_PING    = 2'd2
  } frame_class_t;

  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,
    CMD_XOR  = 2'd1,
    CMD_KEY  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic       emit;
    logic [1:0] idx;
    logic [7:0] data;
    logic       kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       last;
  } out_item_t;

endpackage

@@ design/wsu_front.sv @@
module wsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  wsu_pkg::in_item_t in_item,
  output logic              push,
  output wsu_pkg::cmd_t     cmd
);

  wsu_pkg::phase_t       phase_r, phase_nxt, cur_phase;
  wsu_pkg::frame_class_t class_r, class_nxt;
  logic [15:0]           len_r, len_nxt;
  logic [15:0]           cnt_r, cnt_nxt;
  logic [1:0]            hdr_r, hdr_nxt;
  logic [15:0]           cnt_inc;
  logic [7:0]            b;
  logic                  is_ping;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsu_pkg::PH_OPCODE;
      class_r <= wsu_pkg::CLS_DISCARD;
      len_r   <= '0;
      cnt_r   <= '0;
      hdr_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  always_comb begin
    b         = in_item.data_byte;
    cur_phase = in_item.frame_start ? wsu_pkg::PH_OPCODE : phase_r;
    is_ping   = (class_r == wsu_pkg::CLS_PING);
    cnt_inc   = cnt_r + 16'd1;
    phase_nxt = phase_r;
    class_nxt = class_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    push      = 1'b0;
    cmd.op    = wsu_pkg::CMD_PASS;
    cmd.emit  = 1'b1;
    cmd.idx   = 2'd0;
    cmd.data  = b;
    cmd.kind  = is_ping;
    cmd.last  = 1'b0;
    if (acc) begin
      unique case (cur_phase)
        wsu_pkg::PH_OPCODE: begin
          if (b == wsu_pkg::OPC_TEXT) begin
            class_nxt = wsu_pkg::CLS_TEXT;
          end else if (b == wsu_pkg::OPC_PING) begin
            class_nxt = wsu_pkg::CLS_PING;
          end else begin
            class_nxt = wsu_pkg::CLS_DISCARD;
          end
          len_nxt   = '0;
          cnt_nxt   = '0;
          hdr_nxt   = '0;
          push      = (b == wsu_pkg::OPC_PING);
          cmd.data  = wsu_pkg::OPC_PONG;
          cmd.kind  = 1'b1;
          phase_nxt = wsu_pkg::PH_LENGTH;
        end
        wsu_pkg::PH_LENGTH: begin
          push    = is_ping;
          hdr_nxt = '0;
          if ((b & wsu_pkg::LEN_MASK) >= wsu_pkg::LEN_EXT16) begin
            phase_nxt = wsu_pkg::PH_EXTLEN;
          end else begin
            len_nxt   = {9'd0, b[6:0]};
            phase_nxt = wsu_pkg::PH_MASK;
          end
        end
        wsu_pkg::PH_EXTLEN: begin
          push = is_ping;
          if (hdr_r == 2'd0) begin
            len_nxt = {b, 8'h00};
            hdr_nxt = 2'd1;
          end else begin
            len_nxt   = {len_r[15:8], b};
            hdr_nxt   = 2'd0;
            phase_nxt = wsu_pkg::PH_MASK;
          end
        end
        wsu_pkg::PH_MASK: begin
          push     = is_ping || (class_r == wsu_pkg::CLS_TEXT);
          cmd.op   = wsu_pkg::CMD_KEY;
          cmd.emit = is_ping;
          cmd.idx  = hdr_r;
          cmd.last = (hdr_r == 2'd3) && (len_r == 16'd0);
          if (hdr_r == 2'd3) begin
            hdr_nxt   = 2'd0;
            cnt_nxt   = '0;
            phase_nxt = (len_r == 16'd0) ? wsu_pkg::PH_OPCODE : wsu_pkg::PH_PAYLOAD;
          end else begin
            hdr_nxt = hdr_r + 2'd1;
          end
        end
        wsu_pkg::PH_PAYLOAD: begin
          push     = (class_r != wsu_pkg::CLS_DISCARD);
          cmd.op   = (class_r == wsu_pkg::CLS_TEXT) ? wsu_pkg::CMD_XOR : wsu_pkg::CMD_PASS;
          cmd.idx  = cnt_r[1:0];
          cmd.last = (cnt_inc >= len_r);
          cnt_nxt  = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = wsu_pkg::PH_OPCODE;
          end
        end
        default: begin
          phase_nxt = wsu_pkg::PH_OPCODE;
        end
      endcase
    end
  end

endmodule

@@ design/wsu_queue.sv @@
module wsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsu_pkg::cmd_t push_cmd,
  input  logic          pop,
  output wsu_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  wsu_pkg::cmd_t                mem_r [wsu_pkg::QDEPTH];
  logic [wsu_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [wsu_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [wsu_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  localparam logic [wsu_pkg::QCNT_W-1:0] CNT_FULL = wsu_pkg::QCNT_W'(wsu_pkg::QDEPTH);
  localparam logic [wsu_pkg::QPTR_W-1:0] PTR_LAST = wsu_pkg::QPTR_W'(wsu_pkg::QDEPTH - 1);

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/wsu_back.sv @@
module wsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wsu_pkg::cmd_t      head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wsu_pkg::out_item_t out_data
);

  logic [7:0]         key_r [4];
  logic               valid_r, valid_nxt;
  wsu_pkg::out_item_t data_r, data_nxt;

  assign pop       = !empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    data_nxt  = data_r;
    if (pop) begin
      valid_nxt     = head.emit;
      data_nxt.kind = head.kind;
      data_nxt.last = head.last;
      case (head.op)
        wsu_pkg::CMD_XOR: data_nxt.out_byte = head.data ^ key_r[head.idx];
        default:          data_nxt.out_byte = head.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (pop && (head.op == wsu_pkg::CMD_KEY)) begin
      key_r[head.idx] <= head.data;
    end
  end

endmodule

@@ design/websocket_frame_unmasker.sv @@
// path: a queued byte passes the command queue, then the output register; out_stall holds it
// throughput: one byte per cycle while in_stall is low; 4-entry command queue, output register
// in_stall rises only when the command queue is full
// reset: synchronous active-low rst_n returns the parser to waiting for an opcode byte
// and empties the queue and output register
module websocket_frame_unmasker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wsu_pkg::out_item_t out_data
);

`include "websocket_frame_unmasker_assert.svh"

  logic          in_acc;
  logic          q_push, q_pop, q_full, q_empty;
  logic          opc_non_ping;
  wsu_pkg::cmd_t f_cmd, q_head;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;
  assign opc_non_ping = in_acc && in_data.frame_start &&
                        (in_data.data_byte != wsu_pkg::OPC_PING);

  wsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_item (in_data),
    .push    (q_push),
    .cmd     (f_cmd)
  );

  wsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (f_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `WSU_ASSERT_NOW(a_no_overflow, q_full, !q_push, "push into full queue")
  `WSU_ASSERT_NOW(a_no_underflow, q_empty, !q_pop, "pop from empty queue")
  `WSU_ASSERT_NOW(a_opcode_only_ping, opc_non_ping, !q_push, "non-ping opcode queued")
  `WSU_ASSERT_NEXT(a_pop_fills_out, q_pop && q_head.emit, out_valid, "emitted command lost")

endmodule
